FILE: src/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands used by the top-level RTL file.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, held off during reset
`define ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, held off during reset
`define ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: src/bss_pkg.sv
// ----------------------------------------------------------------------------
// bss_pkg
// Types and constants of the bounded set store.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package bss_pkg;

    localparam int VALUE_W = 32;
    localparam int POS_W   = 4;
    localparam int COUNT_W = 5;

    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_REMOVE = 2'd1,
        OP_QUERY  = 2'd2,
        OP_READ   = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_SCAN,
        ST_RDATA,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic [1:0]                operation;
        logic signed [VALUE_W-1:0] value;
        logic [POS_W-1:0]          position;
    } cmd_t;

    typedef struct packed {
        logic                      found;
        logic signed [VALUE_W-1:0] read_data;
        logic                      rejected;
        logic [COUNT_W-1:0]        entry_count;
    } rsp_t;

endpackage

FILE: src/bss_store.sv
// ----------------------------------------------------------------------------
// bss_store
// Entry memory: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bss_store #(
    parameter int DEPTH  = 16,
    parameter int ADDR_W = 4
) (
    input  logic                           clk,
    input  logic                           we,
    input  logic [ADDR_W-1:0]              waddr,
    input  logic [bss_pkg::VALUE_W-1:0]    wdata,
    input  logic                           re,
    input  logic [ADDR_W-1:0]              raddr,
    output logic [bss_pkg::VALUE_W-1:0]    rdata
);
    import bss_pkg::*;

    logic [VALUE_W-1:0] store_mem [DEPTH];
    logic [VALUE_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            store_mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= store_mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: src/bss_ctrl.sv
// ----------------------------------------------------------------------------
// bss_ctrl
// Sequencer and shared compare unit: walks the store one entry per cycle
// for remove and query, compacting survivors in place on remove.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bss_ctrl #(
    parameter int CAPACITY = 16,
    parameter int ADDR_W   = 4,
    parameter int CNT_W    = 5
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cmd_fire,
    input  bss_pkg::cmd_t                  cmd,
    output logic                           idle,
    output logic                           done,
    input  logic                           take,
    output bss_pkg::rsp_t                  result,
    output logic                           mem_we,
    output logic [ADDR_W-1:0]              mem_waddr,
    output logic [bss_pkg::VALUE_W-1:0]    mem_wdata,
    output logic                           mem_re,
    output logic [ADDR_W-1:0]              mem_raddr,
    input  logic [bss_pkg::VALUE_W-1:0]    mem_rdata
);
    import bss_pkg::*;

    localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

    state_t             state_reg, state_next;
    op_t                op_reg, op_next;
    logic [VALUE_W-1:0] val_reg, val_next;
    logic [POS_W-1:0]   pos_reg, pos_next;
    logic [CNT_W-1:0]   idx_reg, idx_next;
    logic [CNT_W-1:0]   wr_reg, wr_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic               found_reg, found_next;
    logic [VALUE_W-1:0] data_reg, data_next;
    logic               rej_reg, rej_next;

    logic               pos_ok;
    logic               hit;

    assign pos_ok = CMP_W'(pos_reg) < CMP_W'(count_reg);
    assign hit    = (mem_rdata == val_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg    <= op_next;
        val_reg   <= val_next;
        pos_reg   <= pos_next;
        idx_reg   <= idx_next;
        wr_reg    <= wr_next;
        found_reg <= found_next;
        data_reg  <= data_next;
        rej_reg   <= rej_next;
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (cmd_fire)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                unique case (op_reg)
                    OP_INSERT: state_next = ST_FINISH;
                    OP_READ:   state_next = pos_ok ? ST_RDATA : ST_FINISH;
                    OP_REMOVE,
                    OP_QUERY:  state_next = (count_reg == '0) ? ST_FINISH : ST_SCAN;
                endcase
            end
            ST_SCAN:
            begin
                if (idx_reg == count_reg)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_RDATA:
            begin
                state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                if (take)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // datapath and memory control
    always_comb
    begin
        op_next    = op_reg;
        val_next   = val_reg;
        pos_next   = pos_reg;
        idx_next   = idx_reg;
        wr_next    = wr_reg;
        count_next = count_reg;
        found_next = found_reg;
        data_next  = data_reg;
        rej_next   = rej_reg;
        mem_we     = 1'b0;
        mem_waddr  = '0;
        mem_wdata  = '0;
        mem_re     = 1'b0;
        mem_raddr  = '0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (cmd_fire)
                begin
                    op_next    = op_t'(cmd.operation);
                    val_next   = cmd.value;
                    pos_next   = cmd.position;
                    idx_next   = '0;
                    wr_next    = '0;
                    found_next = 1'b0;
                    data_next  = '0;
                    rej_next   = 1'b0;
                end
            end
            ST_EXEC:
            begin
                unique case (op_reg)
                    OP_INSERT:
                    begin
                        if (count_reg < CNT_W'(CAPACITY))
                        begin
                            mem_we     = 1'b1;
                            mem_waddr  = count_reg[ADDR_W-1:0];
                            mem_wdata  = val_reg;
                            count_next = count_reg + 1'b1;
                        end
                        else
                        begin
                            rej_next = 1'b1;
                        end
                    end
                    OP_READ:
                    begin
                        if (pos_ok)
                        begin
                            mem_re    = 1'b1;
                            mem_raddr = ADDR_W'(pos_reg);
                        end
                        else
                        begin
                            rej_next = 1'b1;
                        end
                    end
                    OP_REMOVE,
                    OP_QUERY:
                    begin
                        if (count_reg != '0)
                        begin
                            mem_re    = 1'b1;
                            mem_raddr = '0;
                            idx_next  = CNT_W'(1);
                        end
                    end
                endcase
            end
            ST_SCAN:
            begin
                // entry idx-1 is on the read port; the write pointer never
                // passes the read pointer, so compaction is safe in place
                if (hit)
                begin
                    found_next = 1'b1;
                end
                else if (op_reg == OP_REMOVE)
                begin
                    mem_we    = 1'b1;
                    mem_waddr = wr_reg[ADDR_W-1:0];
                    mem_wdata = mem_rdata;
                    wr_next   = wr_reg + 1'b1;
                end

                if (idx_reg != count_reg)
                begin
                    mem_re    = 1'b1;
                    mem_raddr = idx_reg[ADDR_W-1:0];
                    idx_next  = idx_reg + 1'b1;
                end
                else if (op_reg == OP_REMOVE)
                begin
                    count_next = hit ? wr_reg : wr_reg + 1'b1;
                end
            end
            ST_RDATA:
            begin
                data_next = mem_rdata;
            end
            ST_FINISH:
            begin
            end
            default:
            begin
            end
        endcase
    end

    // status and result
    always_comb
    begin
        idle               = (state_reg == ST_IDLE);
        done               = (state_reg == ST_FINISH);
        result.found       = found_reg;
        result.read_data   = data_reg;
        result.rejected    = rej_reg;
        result.entry_count = COUNT_W'(count_reg);
    end

endmodule

FILE: src/bounded_set_store_unit.sv
// ----------------------------------------------------------------------------
// bounded_set_store_unit
// Ordered store of up to CAPACITY signed 32-bit values with insert,
// remove-all-equal with compaction, membership query and indexed read.
// ----------------------------------------------------------------------------
//   Channel | Handshake             | Payload
//   --------+-----------------------+------------------------------------
//   cmd     | cmd_valid / cmd_ready | bss_pkg::cmd_t (operation, value,
//           |                       |   position)
//   rsp     | rsp_valid / rsp_ready | bss_pkg::rsp_t (found, read_data,
//           |                       |   rejected, entry_count)
//
// One command at a time. Insert goes from EXEC to FINISH, read through EXEC
// and, for a valid position, RDATA; remove and query scan: the single memory
// read port walks the entries one per cycle through the shared comparator.
// Reset clears the fill count; entry contents are undefined until written.
// A stalled rsp holds in the output register while the next cmd is taken.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module bounded_set_store_unit #(
    parameter int CAPACITY = 16
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          cmd_valid,
    output logic          cmd_ready,
    input  bss_pkg::cmd_t cmd,
    output logic          rsp_valid,
    input  logic          rsp_ready,
    output bss_pkg::rsp_t rsp
);
    import bss_pkg::*;

    localparam int ADDR_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W  = $clog2(CAPACITY + 1);

    logic               cmd_fire;
    logic               idle;
    logic               done;
    logic               load;
    rsp_t               result;
    logic               mem_we;
    logic [ADDR_W-1:0]  mem_waddr;
    logic [VALUE_W-1:0] mem_wdata;
    logic               mem_re;
    logic [ADDR_W-1:0]  mem_raddr;
    logic [VALUE_W-1:0] mem_rdata;

    logic               rsp_valid_reg, rsp_valid_next;
    rsp_t               rsp_reg;

    assign cmd_ready = idle;
    assign cmd_fire  = cmd_valid && cmd_ready;

    // advance a finished result into the output register when it is free
    assign load = done && (!rsp_valid_reg || rsp_ready);

    bss_ctrl #(
        .CAPACITY (CAPACITY),
        .ADDR_W   (ADDR_W),
        .CNT_W    (CNT_W)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_fire  (cmd_fire),
        .cmd       (cmd),
        .idle      (idle),
        .done      (done),
        .take      (load),
        .result    (result),
        .mem_we    (mem_we),
        .mem_waddr (mem_waddr),
        .mem_wdata (mem_wdata),
        .mem_re    (mem_re),
        .mem_raddr (mem_raddr),
        .mem_rdata (mem_rdata)
    );

    bss_store #(
        .DEPTH  (CAPACITY),
        .ADDR_W (ADDR_W)
    ) u_store (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        if (load)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            rsp_reg <= result;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    `ASSERT_IMP(a_no_overwrite, clk, rst_n, rsp_valid && !rsp_ready, !load, "rsp overwritten")
    `ASSERT_NXT(a_busy_after_cmd, clk, rst_n, cmd_fire, !cmd_ready, "cmd taken while busy")
    `ASSERT_IMP(a_found_no_reject, clk, rst_n, rsp_valid && rsp.found, !rsp.rejected, "flag clash")
    `ASSERT_IMP(a_found_no_data, clk, rst_n, rsp_valid && rsp.found, rsp.read_data == '0, "data set")

endmodule

FILE: bench/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Testbench for bounded_set_store_unit. A short directed table covers the
// empty store, value extremes, duplicate removal with compaction, a full
// store and out-of-range reads. Random commands follow, values mostly from a small
// value pool so that queries and removes hit stored entries. A behavioral
// copy of the store predicts every response the table does not fix, and
// each response transfer is compared field by field with the oldest
// expectation. Both channels idle in random bursts but for a quiet tail.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;

    import bss_pkg::*;

    localparam int CAPACITY    = 16;
    localparam int RAND_ITEMS  = 1250;
    localparam int QUIET_ITEMS = 150;
    localparam int WINDOW      = 100;
    localparam int POOL_SIZE   = 6;
    localparam int TAIL_CYCLES = 40;
    localparam int CYCLE_LIMIT = 300000;

    typedef struct {
        cmd_t c;
        int   reps;
        bit   typed;
        rsp_t want;
    } plan_row_t;

    logic clk       = 1'b0;
    logic rst_n     = 1'b0;
    logic cmd_valid = 1'b0;
    logic cmd_ready;
    cmd_t cmd       = '0;
    logic rsp_valid;
    logic rsp_ready = 1'b0;
    rsp_t rsp;

    // Travels with the command on the channel: fixed response or predicted
    bit   cmd_typed = 1'b0;
    rsp_t cmd_want  = '0;

    rsp_t        pending_rsp[$];
    plan_row_t   plan[$];
    logic [31:0] set_entries[CAPACITY];
    int          set_fill    = 0;
    int          err_count   = 0;
    int          cycle_count = 0;
    bit          quiet       = 1'b0;
    int          src_pct     = 30;
    int          sink_pct    = 30;

    bounded_set_store_unit #(
        .CAPACITY (CAPACITY)
    ) uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Apply one command to the behavioral store and return its response
    function automatic rsp_t store_op_result(input cmd_t c);
        rsp_t r;
        int   w;
        r = '0;
        case (c.operation)
            OP_INSERT:
            begin
                if (set_fill < CAPACITY)
                begin
                    set_entries[set_fill] = c.value;
                    set_fill++;
                end
                else
                    r.rejected = 1'b1;
            end
            OP_REMOVE:
            begin
                // compact survivors in order
                w = 0;
                for (int i = 0; i < set_fill; i++)
                begin
                    if (set_entries[i] == c.value)
                        r.found = 1'b1;
                    else
                    begin
                        set_entries[w] = set_entries[i];
                        w++;
                    end
                end
                set_fill = w;
            end
            OP_QUERY:
            begin
                for (int i = 0; i < set_fill; i++)
                    if (set_entries[i] == c.value)
                        r.found = 1'b1;
            end
            default:
            begin
                if (int'(c.position) < set_fill)
                    r.read_data = set_entries[c.position];
                else
                    r.rejected = 1'b1;
            end
        endcase
        r.entry_count = set_fill[COUNT_W-1:0];
        return r;
    endfunction

    function automatic void add_row(input op_t op, input logic [31:0] v, input logic [3:0] p,
                                    input int reps, input bit typed, input logic f,
                                    input logic [31:0] d, input logic rj, input logic [4:0] n);
        plan_row_t row;
        row.c.operation       = op;
        row.c.value           = v;
        row.c.position        = p;
        row.reps              = reps;
        row.typed             = typed;
        row.want.found        = f;
        row.want.read_data    = d;
        row.want.rejected     = rj;
        row.want.entry_count  = n;
        plan.push_back(row);
    endfunction

    task automatic flag_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
        $display("tb: mismatch on %s: got %h, expected %h (cycle %0d)",
                 what, got, want, cycle_count);
        err_count++;
    endtask

    // Present one command and hold it until the transfer
    task automatic issue_cmd(input cmd_t c, input bit typed, input rsp_t want);
        cmd       <= c;
        cmd_valid <= 1'b1;
        cmd_typed <= typed;
        cmd_want  <= want;
        @(posedge clk);
        while (!cmd_ready)
            @(posedge clk);
    endtask

    task automatic hold_off();
        if (!quiet && $urandom_range(0, 99) < src_pct)
        begin
            cmd_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
    endtask

    task automatic drain_wait();
        cmd_valid <= 1'b0;
        @(posedge clk);
        while (pending_rsp.size() != 0)
            @(posedge clk);
    endtask

    always @(posedge clk)
    begin : scoreboard
        rsp_t held;
        rsp_t predicted;
        if (rst_n)
        begin
            // check the response before queueing this edge's command
            if (rsp_valid && rsp_ready)
            begin
                if (pending_rsp.size() == 0)
                    flag_mismatch("response with nothing outstanding",
                                  rsp.read_data, 32'd0);
                else
                begin
                    held = pending_rsp.pop_front();
                    if (rsp.found !== held.found)
                        flag_mismatch("found", 32'(rsp.found), 32'(held.found));
                    if (rsp.read_data !== held.read_data)
                        flag_mismatch("read_data", rsp.read_data, held.read_data);
                    if (rsp.rejected !== held.rejected)
                        flag_mismatch("rejected", 32'(rsp.rejected), 32'(held.rejected));
                    if (rsp.entry_count !== held.entry_count)
                        flag_mismatch("entry_count", 32'(rsp.entry_count),
                                      32'(held.entry_count));
                end
            end
            if (cmd_valid && cmd_ready)
            begin
                predicted = store_op_result(cmd);
                pending_rsp.push_back(cmd_typed ? cmd_want : predicted);
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    initial
    begin : rsp_sink
        wait (rst_n);
        forever
        begin
            @(posedge clk);
            if (!quiet && $urandom_range(0, 99) < sink_pct)
            begin
                rsp_ready <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge clk);
            end
            rsp_ready <= 1'b1;
        end
    end

    initial
    begin : stimulus
        cmd_t        c;
        logic [31:0] pool[POOL_SIZE];
        int          roll;
        int          cut_ins;
        int          cut_rem;
        int          cut_qry;

        // Empty store, extremes, duplicates, full store, reads at the edges
        add_row(OP_READ,   32'h0000_0000, 4'd0,  1,  1, 1'b0, 32'h0, 1'b1, 5'd0);
        add_row(OP_REMOVE, 32'h0000_0000, 4'd0,  1,  1, 1'b0, 32'h0, 1'b0, 5'd0);
        add_row(OP_INSERT, 32'h8000_0000, 4'd0,  1,  0, 1'b0, 32'h0, 1'b0, 5'd0);
        add_row(OP_INSERT, 32'hFFFF_FFFF, 4'd0,  1,  0, 1'b0, 32'h0, 1'b0, 5'd0);
        add_row(OP_INSERT, 32'hFFFF_FFFF, 4'd0,  1,  0, 1'b0, 32'h0, 1'b0, 5'd0);
        add_row(OP_QUERY,  32'h8000_0000, 4'd0,  1,  0, 1'b0, 32'h0, 1'b0, 5'd0);
        add_row(OP_REMOVE, 32'hFFFF_FFFF, 4'd0,  1,  0, 1'b0, 32'h0, 1'b0, 5'd0);
        add_row(OP_READ,   32'h0000_0000, 4'd0,  1,  0, 1'b0, 32'h0, 1'b0, 5'd0);
        add_row(OP_READ,   32'hFFFF_FFFF, 4'd1,  1,  1, 1'b0, 32'h0, 1'b1, 5'd1);
        add_row(OP_INSERT, 32'h7FFF_FFFF, 4'd0,  15, 0, 1'b0, 32'h0, 1'b0, 5'd0);
        add_row(OP_INSERT, 32'h0000_0000, 4'd0,  1,  1, 1'b0, 32'h0, 1'b1, 5'd16);
        add_row(OP_READ,   32'h0000_0000, 4'd15, 1,  1, 1'b0, 32'h7FFF_FFFF, 1'b0, 5'd16);
        add_row(OP_QUERY,  32'h0000_0000, 4'd0,  1,  1, 1'b0, 32'h0, 1'b0, 5'd16);
        add_row(OP_REMOVE, 32'h7FFF_FFFF, 4'd0,  1,  1, 1'b1, 32'h0, 1'b0, 5'd1);
        add_row(OP_READ,   32'h0000_0000, 4'd0,  1,  0, 1'b0, 32'h0, 1'b0, 5'd0);

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (plan[r])
        begin
            for (int k = 0; k < plan[r].reps; k++)
            begin
                issue_cmd(plan[r].c, plan[r].typed, plan[r].want);
                hold_off();
            end
        end
        drain_wait();

        cut_ins = 35;
        cut_rem = 55;
        cut_qry = 75;
        for (int i = 0; i < RAND_ITEMS; i++)
        begin
            if (i % WINDOW == 0)
            begin
                // new window: operation mix, idle rates and value pool
                case ($urandom_range(0, 2))
                    0:
                    begin
                        cut_ins = 55;
                        cut_rem = 65;
                        cut_qry = 80;
                    end
                    1:
                    begin
                        cut_ins = 25;
                        cut_rem = 60;
                        cut_qry = 80;
                    end
                    default:
                    begin
                        cut_ins = 35;
                        cut_rem = 55;
                        cut_qry = 75;
                    end
                endcase
                src_pct  = 20 * $urandom_range(0, 2);
                sink_pct = 20 * $urandom_range(0, 2);
                for (int j = 0; j < POOL_SIZE; j++)
                begin
                    case ($urandom_range(0, 7))
                        0:       pool[j] = 32'h8000_0000;
                        1:       pool[j] = 32'h7FFF_FFFF;
                        2:       pool[j] = 32'h0000_0000;
                        3:       pool[j] = 32'hFFFF_FFFF;
                        default: pool[j] = $urandom;
                    endcase
                end
            end
            if (i == RAND_ITEMS / 2)
                drain_wait();
            if (i == RAND_ITEMS - QUIET_ITEMS)
                quiet = 1'b1;

            roll = $urandom_range(0, 99);
            if (roll < cut_ins)
                c.operation = OP_INSERT;
            else if (roll < cut_rem)
                c.operation = OP_REMOVE;
            else if (roll < cut_qry)
                c.operation = OP_QUERY;
            else
                c.operation = OP_READ;
            if ($urandom_range(0, 3) != 0)
                c.value = pool[$urandom_range(0, POOL_SIZE - 1)];
            else
                c.value = $urandom;
            if ($urandom_range(0, 1) != 0)
                c.position = 4'($urandom_range(0, 15));
            else
                c.position = 4'($urandom_range(0, 4));
            issue_cmd(c, 1'b0, '0);
            hold_off();
        end

        drain_wait();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (err_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
